// ----- sv/depth_pixel_backproject_semantic_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the depth pixel back-projection block
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DEPTH_PIXEL_BACKPROJECT_SEMANTIC_ASSERT_SVH
`define DEPTH_PIXEL_BACKPROJECT_SEMANTIC_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define DPBS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DPBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DPBS_ASSERT_IMPL(lbl, ante, cons, msg)
`define DPBS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- sv/dpbs_pkg.sv -----
// ----------------------------------------------------------------------------
// dpbs_pkg
// Types, constants and helpers shared by the depth back-projection block.
// ----------------------------------------------------------------------------
package dpbs_pkg;

  // Default size of the class color table.
  localparam int NUM_CLASSES_DEF = 80;

  // Validity window on the full Q.24 depth product: 0.01 m < z <= 10 m.
  localparam logic [39:0] Z_LOW_FULL  = 40'd167772;
  localparam logic [39:0] Z_HIGH_FULL = 40'd167772160;

  // Classes that describe moving objects: 0-3, 5-7 and 14-19.
  localparam logic [19:0] DYNAMIC_MASK = 20'h0FC0EF;

  // Register reset values.
  localparam logic [23:0] DEPTH_SCALE_RST = 24'd16777;
  localparam logic [23:0] INV_FOCAL_X_RST = 24'd29434;
  localparam logic [23:0] INV_FOCAL_Y_RST = 24'd29434;
  localparam logic [19:0] CENTER_X_RST    = 20'd81920;
  localparam logic [19:0] CENTER_Y_RST    = 20'd61440;

  // Configuration register indexes (byte address is four times the index).
  typedef enum logic [2:0] {
    REG_DEPTH_SCALE = 3'd0,
    REG_INV_FOCAL_X = 3'd1,
    REG_INV_FOCAL_Y = 3'd2,
    REG_CENTER_X    = 3'd3,
    REG_CENTER_Y    = 3'd4
  } dpbs_reg_e;

  // Input item kinds.
  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_LOAD  = 1'b1
  } dpbs_action_e;

  // One input item.
  typedef struct packed {
    logic        action;
    logic [11:0] col;
    logic [11:0] row_index;
    logic [15:0] depth_raw;
    logic [7:0]  label_code;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [6:0]  color_slot;
  } dpbs_in_t;

  // One result item.
  typedef struct packed {
    logic               point_valid;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [19:0]        point_z;
    logic [7:0]         red_out;
    logic [7:0]         green_out;
    logic [7:0]         blue_out;
  } dpbs_out_t;

  // Load enables of the three pipeline stages ahead of the output register.
  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
  } dpbs_stage_en_t;

  // True when the label names one of the dynamic classes.
  function automatic logic is_dynamic(input logic [7:0] label);
    logic [7:0] cls;
    cls = label - 8'd1;
    is_dynamic = (label != 8'd0) && (cls < 8'd20) && DYNAMIC_MASK[cls[4:0]];
  endfunction

endpackage

// ----- sv/depth_pixel_backproject_semantic.sv -----
// ----------------------------------------------------------------------------
// depth_pixel_backproject_semantic
// Turns depth pixels into colored 3-D points and keeps a class color table
// that load items fill.
//
//   Channel   Direction  Handshake                 Content
//   input     in         in_valid_i / in_stall_o   dpbs_in_t (pixel or load)
//   output    out        out_valid_o / out_stall_i dpbs_out_t (one per pixel)
//   config    in         APB write / read          five registers at 4*i
//
// One item is taken every cycle while in_stall_o is low. A pixel result
// passes the color table read and depth product, then the two multiplier
// stages of each axis, then the output register.
// A load item writes the table at its transfer and gives no result.
// Reset clears the registers to their defaults; the table is not cleared.
// in_stall_o rises only when every stage holds a result behind a stalled
// output.
// ----------------------------------------------------------------------------
module depth_pixel_backproject_semantic
  import dpbs_pkg::*;
#(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  dpbs_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output dpbs_out_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam logic [8:0] CLS_LIMIT = 9'(NUM_CLASSES);

  // Configuration registers.
  logic [23:0] depth_scale_q, inv_focal_x_q, inv_focal_y_q;
  logic [19:0] center_x_q, center_y_q;
  logic        cfg_wr;
  dpbs_reg_e   cfg_idx;

  // Pipeline control.
  logic           s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic           ready_out, ready3, ready2, ready1;
  logic           in_xfer, pix_xfer, load_xfer;
  dpbs_stage_en_t stage_en;

  // Pipeline payload.
  logic [39:0] full_d, full_q;
  logic        dyn_q, use_table_q;
  logic [23:0] cam_rgb_q;
  logic        ok2_q, ok3_q;
  logic [19:0] z2_q, z3_q;
  logic [23:0] rgb2_q, rgb3_q;
  dpbs_out_t   out_d, out_q;

  // Table access.
  logic [7:0]    cls;
  logic          use_table_d;
  logic          load_in_range;
  logic [7:0]    slot_ext;
  logic [23:0]   table_rgb;
  logic signed [31:0] coord_x, coord_y;

  // --------------------------------------------------------------------------
  // Configuration port: writes complete in the access phase; reads are direct.
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = dpbs_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_scale_q <= DEPTH_SCALE_RST;
      inv_focal_x_q <= INV_FOCAL_X_RST;
      inv_focal_y_q <= INV_FOCAL_Y_RST;
      center_x_q    <= CENTER_X_RST;
      center_y_q    <= CENTER_Y_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DEPTH_SCALE: depth_scale_q <= pwdata[23:0];
        REG_INV_FOCAL_X: inv_focal_x_q <= pwdata[23:0];
        REG_INV_FOCAL_Y: inv_focal_y_q <= pwdata[23:0];
        REG_CENTER_X:    center_x_q    <= pwdata[19:0];
        REG_CENTER_Y:    center_y_q    <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DEPTH_SCALE: prdata = {8'd0, depth_scale_q};
      REG_INV_FOCAL_X: prdata = {8'd0, inv_focal_x_q};
      REG_INV_FOCAL_Y: prdata = {8'd0, inv_focal_y_q};
      REG_CENTER_X:    prdata = {12'd0, center_x_q};
      REG_CENTER_Y:    prdata = {12'd0, center_y_q};
      default:         prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or its successor moves on.
  // --------------------------------------------------------------------------
  assign ready_out = !out_valid_q || !out_stall_i;
  assign ready3    = !s3_valid_q || ready_out;
  assign ready2    = !s2_valid_q || ready3;
  assign ready1    = !s1_valid_q || ready2;

  assign stage_en.s1_en = ready1;
  assign stage_en.s2_en = ready2;
  assign stage_en.s3_en = ready3;

  assign in_stall_o = !ready1;
  assign in_xfer    = in_valid_i && ready1;
  assign pix_xfer   = in_xfer && (in_data_i.action == ACT_PIXEL);
  assign load_xfer  = in_xfer && (in_data_i.action == ACT_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready1) begin
        s1_valid_q <= pix_xfer;
      end
      if (ready2) begin
        s2_valid_q <= s1_valid_q;
      end
      if (ready3) begin
        s3_valid_q <= s2_valid_q;
      end
      if (ready_out) begin
        out_valid_q <= s3_valid_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Color table: loads write at their transfer, pixels read at theirs, so
  // accesses happen in item order and need no forwarding.
  // --------------------------------------------------------------------------
  assign cls           = in_data_i.label_code - 8'd1;
  assign use_table_d   = (in_data_i.label_code != 8'd0) && ({1'b0, cls} < CLS_LIMIT);
  assign slot_ext      = {1'b0, in_data_i.color_slot};
  assign load_in_range = {1'b0, slot_ext} < CLS_LIMIT;

  dpbs_color_mem #(
    .NUM_CLASSES (NUM_CLASSES),
    .AW          (AW)
  ) u_color_mem (
    .clk_i     (clk_i),
    .wr_en_i   (load_xfer && load_in_range),
    .wr_addr_i (slot_ext[AW-1:0]),
    .wr_data_i ({in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in}),
    .rd_en_i   (pix_xfer && use_table_d),
    .rd_addr_i (cls[AW-1:0]),
    .rd_data_o (table_rgb)
  );

  // --------------------------------------------------------------------------
  // Stage 1: full depth product and label decode.
  // --------------------------------------------------------------------------
  assign full_d = 40'(in_data_i.depth_raw) * 40'(depth_scale_q);

  always_ff @(posedge clk_i) begin
    if (ready1) begin
      full_q      <= full_d;
      dyn_q       <= is_dynamic(in_data_i.label_code);
      use_table_q <= use_table_d;
      cam_rgb_q   <= {in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: depth window, z in Q4.16 and color selection.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (ready2) begin
      ok2_q  <= (full_q > Z_LOW_FULL) && (full_q <= Z_HIGH_FULL) && !dyn_q;
      z2_q   <= full_q[27:8];
      rgb2_q <= use_table_q ? table_rgb : cam_rgb_q;
    end
  end

  // Stage 3: carry the point data beside the final multiplier stage.
  always_ff @(posedge clk_i) begin
    if (ready3) begin
      ok3_q  <= ok2_q;
      z3_q   <= z2_q;
      rgb3_q <= rgb2_q;
    end
  end

  // Both axes share the stage enables with the main pipeline.
  dpbs_project u_project_x (
    .clk_i    (clk_i),
    .en_i     (stage_en),
    .pix_i    (in_data_i.col),
    .center_i (center_x_q),
    .z_i      (full_q[27:8]),
    .inv_i    (inv_focal_x_q),
    .coord_o  (coord_x)
  );

  dpbs_project u_project_y (
    .clk_i    (clk_i),
    .en_i     (stage_en),
    .pix_i    (in_data_i.row_index),
    .center_i (center_y_q),
    .z_i      (full_q[27:8]),
    .inv_i    (inv_focal_y_q),
    .coord_o  (coord_y)
  );

  // --------------------------------------------------------------------------
  // Output register: an invalid point reads as all zero.
  // --------------------------------------------------------------------------
  always_comb begin
    out_d.point_valid = ok3_q;
    out_d.point_x     = ok3_q ? coord_x : 32'sd0;
    out_d.point_y     = ok3_q ? coord_y : 32'sd0;
    out_d.point_z     = ok3_q ? z3_q : 20'd0;
    out_d.red_out     = ok3_q ? rgb3_q[23:16] : 8'd0;
    out_d.green_out   = ok3_q ? rgb3_q[15:8] : 8'd0;
    out_d.blue_out    = ok3_q ? rgb3_q[7:0] : 8'd0;
  end

  always_ff @(posedge clk_i) begin
    if (ready_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`include "depth_pixel_backproject_semantic_assert.svh"

  `DPBS_ASSERT_IMPL(a_invalid_zero, out_valid_o && !out_data_o.point_valid, (out_data_o.point_x == 32'sd0) && (out_data_o.point_y == 32'sd0) && (out_data_o.point_z == 20'd0) && (out_data_o.red_out == 8'd0) && (out_data_o.green_out == 8'd0) && (out_data_o.blue_out == 8'd0), "invalid point carries nonzero data")
  `DPBS_ASSERT_IMPL(a_z_window, out_valid_o && out_data_o.point_valid, (out_data_o.point_z != 20'd0) && (out_data_o.point_z <= 20'd655360), "valid point depth outside window")
  `DPBS_ASSERT_IMPL(a_stall_full, in_stall_o, s1_valid_q && s2_valid_q && s3_valid_q && out_valid_q, "input stalled with an empty stage")
  `DPBS_ASSERT_NEXT(a_no_drop, s3_valid_q && out_valid_q && out_stall_i, s3_valid_q && out_valid_q, "result lost under output stall")

endmodule

// ----- sv/dpbs_color_mem.sv -----
// ----------------------------------------------------------------------------
// dpbs_color_mem
// Class color table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dpbs_color_mem
  import dpbs_pkg::*;
#(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int AW          = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [23:0]   wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [23:0]   rd_data_o
);

  logic [23:0] mem [NUM_CLASSES];
  logic [23:0] rd_data_q;

  // Write port; the caller only issues addresses inside the table.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port with registered data; the data holds while not enabled.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- sv/dpbs_project.sv -----
// ----------------------------------------------------------------------------
// dpbs_project
// One axis of the back-projection: offset from the principal point, times
// depth, times the focal reciprocal, then truncation and saturation.
// ----------------------------------------------------------------------------
module dpbs_project
  import dpbs_pkg::*;
(
  input  logic               clk_i,
  input  dpbs_stage_en_t     en_i,
  input  logic [11:0]        pix_i,
  input  logic [19:0]        center_i,
  input  logic [19:0]        z_i,
  input  logic [23:0]        inv_i,
  output logic signed [31:0] coord_o
);

  logic [19:0] pos;
  logic        neg_d;
  logic [19:0] mag_d;
  logic        neg1_q, neg2_q, neg3_q;
  logic [19:0] mag_q;
  logic [39:0] prod1_q;
  logic [63:0] prod2_q;
  logic [31:0] hi;
  logic [31:0] sat_mag;

  // Stage 1: signed offset of the pixel from the center, as sign and magnitude.
  assign pos   = {pix_i, 8'd0};
  assign neg_d = pos < center_i;
  assign mag_d = neg_d ? (center_i - pos) : (pos - center_i);

  always_ff @(posedge clk_i) begin
    if (en_i.s1_en) begin
      neg1_q <= neg_d;
      mag_q  <= mag_d;
    end
  end

  // Stage 2: magnitude times depth.
  always_ff @(posedge clk_i) begin
    if (en_i.s2_en) begin
      neg2_q  <= neg1_q;
      prod1_q <= 40'(mag_q) * 40'(z_i);
    end
  end

  // Stage 3: times the focal reciprocal, full 64-bit product.
  always_ff @(posedge clk_i) begin
    if (en_i.s3_en) begin
      neg3_q  <= neg2_q;
      prod2_q <= 64'(prod1_q) * 64'(inv_i);
    end
  end

  // Drop 32 fraction bits, clamp to the signed 32-bit range and apply the sign.
  assign hi = prod2_q[63:32];

  always_comb begin
    if (neg3_q) begin
      sat_mag = (hi > 32'h8000_0000) ? 32'h8000_0000 : hi;
      coord_o = signed'(32'd0 - sat_mag);
    end else begin
      sat_mag = hi[31] ? 32'h7FFF_FFFF : hi;
      coord_o = signed'(sat_mag);
    end
  end

endmodule
